[design/gn3_pkg.sv]
// ----------------------------------------------------------------------------
// gn3_pkg
// Shared constants, codes and stage types of the 3D gradient noise block.
// ----------------------------------------------------------------------------
package gn3_pkg;

   localparam int TABLE_SIZE = 256;
   localparam int FRAC_W     = 16;
   localparam int IDX_W      = $clog2(TABLE_SIZE);

   localparam int COORD_W = 32;
   localparam int GRAD_W  = 16;
   localparam int PERM_W  = 8;
   localparam int TIDX_W  = 8;
   localparam int OUT_W   = 21;

   localparam int T_W    = FRAC_W + 1;
   localparam int D_W    = FRAC_W + 2;
   localparam int K_W    = FRAC_W + 2;
   localparam int TT_W   = 2 * T_W;
   localparam int FP_W   = T_W + K_W;
   localparam int PROD_W = GRAD_W + D_W;
   localparam int SUM_W  = PROD_W + 2;
   localparam int VAL_W  = SUM_W - (FRAC_W - 2);
   localparam int MUL_W  = VAL_W + T_W + 1;
   localparam int ACC_W  = VAL_W + 3;

   localparam logic [D_W-1:0] ONE_D     = {2'b01, {FRAC_W{1'b0}}};
   localparam logic [T_W-1:0] ONE_T     = {1'b1, {FRAC_W{1'b0}}};
   localparam logic [K_W-1:0] THREE_ONE = {2'b11, {FRAC_W{1'b0}}};

   localparam logic signed [ACC_W-1:0] OUT_MAX = ACC_W'((1 << (OUT_W - 1)) - 1);
   localparam logic signed [ACC_W-1:0] OUT_MIN = -ACC_W'(1 << (OUT_W - 1));

   typedef enum logic [1:0] {
      REQ_LOAD_PERM = 2'd0,
      REQ_LOAD_GRAD = 2'd1,
      REQ_EVALUATE  = 2'd2
   } req_code_type;

   typedef enum logic [1:0] {
      OP_LOAD_PERM,
      OP_LOAD_GRAD,
      OP_CORNER
   } op_kind_type;

   typedef logic [IDX_W-1:0] idx_type;

   typedef struct packed {
      logic                     valid;
      op_kind_type              kind;
      logic                     last;
      idx_type                  qx;
      idx_type                  qy;
      idx_type                  qz;
      logic signed [D_W-1:0]    dx;
      logic signed [D_W-1:0]    dy;
      logic signed [D_W-1:0]    dz;
      logic [T_W-1:0]           tx;
      logic [T_W-1:0]           ty;
      logic [T_W-1:0]           tz;
      idx_type                  load_index;
      logic [PERM_W-1:0]        perm_value;
      logic signed [GRAD_W-1:0] gx;
      logic signed [GRAD_W-1:0] gy;
      logic signed [GRAD_W-1:0] gz;
   } corner_op_type;

   typedef struct packed {
      logic                     valid;
      logic                     last;
      logic signed [D_W-1:0]    dx;
      logic signed [D_W-1:0]    dy;
      logic signed [D_W-1:0]    dz;
      logic signed [GRAD_W-1:0] gx;
      logic signed [GRAD_W-1:0] gy;
      logic signed [GRAD_W-1:0] gz;
      logic [T_W-1:0]           wx;
      logic [T_W-1:0]           wy;
      logic [T_W-1:0]           wz;
   } term_type;

endpackage

[design/gn3_issue.sv]
// ----------------------------------------------------------------------------
// gn3_issue
// Accepts request transfers and issues one lattice corner per cycle while adv is high.
// ----------------------------------------------------------------------------
module gn3_issue (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                adv,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_type,
   input  logic [gn3_pkg::TIDX_W-1:0]          req_table_index,
   input  logic [gn3_pkg::PERM_W-1:0]          req_perm_value,
   input  logic signed [gn3_pkg::GRAD_W-1:0]   req_grad_x,
   input  logic signed [gn3_pkg::GRAD_W-1:0]   req_grad_y,
   input  logic signed [gn3_pkg::GRAD_W-1:0]   req_grad_z,
   input  logic signed [gn3_pkg::COORD_W-1:0]  req_coord_x,
   input  logic signed [gn3_pkg::COORD_W-1:0]  req_coord_y,
   input  logic signed [gn3_pkg::COORD_W-1:0]  req_coord_z,
   output gn3_pkg::corner_op_type              op_out
);

   logic                               busy_ff, busy_in;
   logic [2:0]                         corner_ff, corner_in;
   logic signed [gn3_pkg::COORD_W-1:0] coord_ff [3];
   gn3_pkg::corner_op_type             op_ff, op_in;

   logic                               accept;
   logic signed [gn3_pkg::COORD_W-1:0] src [3];
   logic signed [gn3_pkg::COORD_W-1:0] base [3];
   logic [gn3_pkg::FRAC_W-1:0]         frac [3];
   gn3_pkg::idx_type                   q [3];
   logic signed [gn3_pkg::D_W-1:0]     d [3];
   logic [gn3_pkg::T_W-1:0]            t [3];
   logic [2:0]                         corner;
   logic                               index_ok;

   assign req_ready = adv && !busy_ff;
   assign accept    = req_valid && req_ready;
   assign index_ok  = 32'(req_table_index) < 32'(gn3_pkg::TABLE_SIZE);
   assign corner    = busy_ff ? corner_ff : 3'd0;

   always_comb begin
      src[0] = busy_ff ? coord_ff[0] : req_coord_x;
      src[1] = busy_ff ? coord_ff[1] : req_coord_y;
      src[2] = busy_ff ? coord_ff[2] : req_coord_z;
      for (int a = 0; a < 3; a++) begin
         base[a] = src[a] >>> gn3_pkg::FRAC_W;
         frac[a] = src[a][gn3_pkg::FRAC_W-1:0];
         q[a]    = base[a][gn3_pkg::IDX_W-1:0] + gn3_pkg::idx_type'(corner[a]);
         if (corner[a]) begin
            d[a] = {2'b00, frac[a]} - gn3_pkg::ONE_D;
            t[a] = {1'b0, frac[a]};
         end else begin
            d[a] = {2'b00, frac[a]};
            t[a] = gn3_pkg::ONE_T - {1'b0, frac[a]};
         end
      end
   end

   always_comb begin
      op_in            = '0;
      op_in.qx         = q[0];
      op_in.qy         = q[1];
      op_in.qz         = q[2];
      op_in.dx         = d[0];
      op_in.dy         = d[1];
      op_in.dz         = d[2];
      op_in.tx         = t[0];
      op_in.ty         = t[1];
      op_in.tz         = t[2];
      op_in.last       = (corner == 3'd7);
      op_in.load_index = gn3_pkg::idx_type'(req_table_index);
      op_in.perm_value = req_perm_value;
      op_in.gx         = req_grad_x;
      op_in.gy         = req_grad_y;
      op_in.gz         = req_grad_z;
      op_in.kind       = gn3_pkg::OP_CORNER;
      if (busy_ff) begin
         op_in.valid = 1'b1;
      end else if (accept) begin
         case (req_type)
            gn3_pkg::REQ_LOAD_PERM: begin
               op_in.valid = index_ok;
               op_in.kind  = gn3_pkg::OP_LOAD_PERM;
            end
            gn3_pkg::REQ_LOAD_GRAD: begin
               op_in.valid = index_ok;
               op_in.kind  = gn3_pkg::OP_LOAD_GRAD;
            end
            gn3_pkg::REQ_EVALUATE: begin
               op_in.valid = 1'b1;
            end
            default: begin
               op_in.valid = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      busy_in   = busy_ff;
      corner_in = corner_ff;
      if (busy_ff && adv) begin
         corner_in = corner_ff + 3'd1;
         if (corner_ff == 3'd7) begin
            busy_in = 1'b0;
         end
      end else if (accept && req_type == gn3_pkg::REQ_EVALUATE) begin
         busy_in   = 1'b1;
         corner_in = 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         corner_ff <= 3'd0;
         op_ff     <= '0;
      end else begin
         busy_ff   <= busy_in;
         corner_ff <= corner_in;
         if (adv) begin
            op_ff <= op_in;
         end
      end
   end

   // hold the point for the remaining corners
   always_ff @(posedge clock) begin
      if (accept && req_type == gn3_pkg::REQ_EVALUATE) begin
         coord_ff[0] <= req_coord_x;
         coord_ff[1] <= req_coord_y;
         coord_ff[2] <= req_coord_z;
      end
   end

   assign op_out = op_ff;

endmodule

[design/gn3_lookup.sv]
// ----------------------------------------------------------------------------
// gn3_lookup
// Nested permutation hash, gradient fetch and fade weights, four stages.
// ----------------------------------------------------------------------------
module gn3_lookup (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  gn3_pkg::corner_op_type op_in,
   output gn3_pkg::term_type      term_out
);

   localparam int F = gn3_pkg::FRAC_W;

   // one copy of the permutation table per hash level, written in step
   logic [gn3_pkg::PERM_W-1:0]     perm0 [gn3_pkg::TABLE_SIZE];
   logic [gn3_pkg::PERM_W-1:0]     perm1 [gn3_pkg::TABLE_SIZE];
   logic [gn3_pkg::PERM_W-1:0]     perm2 [gn3_pkg::TABLE_SIZE];
   logic [3*gn3_pkg::GRAD_W-1:0]   grad_mem [gn3_pkg::TABLE_SIZE];

   gn3_pkg::corner_op_type         s1_ff, s2_ff, s3_ff, s4_ff;
   logic [gn3_pkg::PERM_W-1:0]     pa_ff, pb_ff, h_ff;
   logic [3*gn3_pkg::GRAD_W-1:0]   grad_ff;
   logic [gn3_pkg::TT_W-1:0]       tt_ff [3];
   logic [gn3_pkg::FP_W-1:0]       fp_ff [3];
   logic [gn3_pkg::T_W-1:0]        w3_ff [3];
   logic [gn3_pkg::T_W-1:0]        w4_ff [3];

   logic [gn3_pkg::T_W-1:0]        t0 [3];
   logic [gn3_pkg::T_W-1:0]        t1 [3];
   logic [gn3_pkg::T_W-1:0]        t2 [3];
   logic [gn3_pkg::K_W-1:0]        k1 [3];
   gn3_pkg::idx_type               addr1, addr2, addr3;

   assign addr1 = s1_ff.qy + gn3_pkg::idx_type'(pa_ff);
   assign addr2 = s2_ff.qz + gn3_pkg::idx_type'(pb_ff);
   assign addr3 = gn3_pkg::idx_type'(h_ff);

   always_comb begin
      t0[0] = op_in.tx;
      t0[1] = op_in.ty;
      t0[2] = op_in.tz;
      t1[0] = s1_ff.tx;
      t1[1] = s1_ff.ty;
      t1[2] = s1_ff.tz;
      for (int a = 0; a < 3; a++) begin
         t2[a] = tt_ff[a][2*F:F];
         k1[a] = gn3_pkg::THREE_ONE - {t1[a], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= '0;
         s2_ff <= '0;
         s3_ff <= '0;
         s4_ff <= '0;
      end else if (adv) begin
         s1_ff <= op_in;
         s2_ff <= s1_ff;
         s3_ff <= s2_ff;
         s4_ff <= s3_ff;
      end
   end

   // each table copy is written at the stage that reads it, keeping order
   always_ff @(posedge clock) begin
      if (adv) begin
         if (op_in.valid && op_in.kind == gn3_pkg::OP_LOAD_PERM) begin
            perm0[op_in.load_index] <= op_in.perm_value;
         end
         pa_ff <= perm0[op_in.qx];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         if (s1_ff.valid && s1_ff.kind == gn3_pkg::OP_LOAD_PERM) begin
            perm1[s1_ff.load_index] <= s1_ff.perm_value;
         end
         pb_ff <= perm1[addr1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         if (s2_ff.valid && s2_ff.kind == gn3_pkg::OP_LOAD_PERM) begin
            perm2[s2_ff.load_index] <= s2_ff.perm_value;
         end
         h_ff <= perm2[addr2];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         if (s3_ff.valid && s3_ff.kind == gn3_pkg::OP_LOAD_GRAD) begin
            grad_mem[s3_ff.load_index] <= {s3_ff.gx, s3_ff.gy, s3_ff.gz};
         end
         grad_ff <= grad_mem[addr3];
      end
   end

   // fade 3t^2 - 2t^3: square, times (3 - 2t), rescale
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int a = 0; a < 3; a++) begin
            tt_ff[a] <= t0[a] * t0[a];
            fp_ff[a] <= t2[a] * k1[a];
            w3_ff[a] <= fp_ff[a][2*F:F];
            w4_ff[a] <= w3_ff[a];
         end
      end
   end

   always_comb begin
      term_out.valid = s4_ff.valid && s4_ff.kind == gn3_pkg::OP_CORNER;
      term_out.last  = s4_ff.last;
      term_out.dx    = s4_ff.dx;
      term_out.dy    = s4_ff.dy;
      term_out.dz    = s4_ff.dz;
      term_out.gx    = grad_ff[3*gn3_pkg::GRAD_W-1:2*gn3_pkg::GRAD_W];
      term_out.gy    = grad_ff[2*gn3_pkg::GRAD_W-1:gn3_pkg::GRAD_W];
      term_out.gz    = grad_ff[gn3_pkg::GRAD_W-1:0];
      term_out.wx    = w4_ff[0];
      term_out.wy    = w4_ff[1];
      term_out.wz    = w4_ff[2];
   end

endmodule

[design/gn3_weight.sv]
// ----------------------------------------------------------------------------
// gn3_weight
// Dot product, three fade weightings, corner sum and the result register.
// ----------------------------------------------------------------------------
module gn3_weight (
   input  logic                             clock,
   input  logic                             reset,
   input  gn3_pkg::term_type                term_in,
   output logic                             adv,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic signed [gn3_pkg::OUT_W-1:0] rsp_noise_value
);

   localparam int F = gn3_pkg::FRAC_W;

   logic                              a_valid_ff, a_last_ff;
   logic signed [gn3_pkg::PROD_W-1:0] p_ff [3];
   logic [gn3_pkg::T_W-1:0]           wa_ff [3];
   logic                              b_valid_ff, b_last_ff;
   logic signed [gn3_pkg::VAL_W-1:0]  vb_ff;
   logic [gn3_pkg::T_W-1:0]           wb_ff [3];
   logic                              c_valid_ff, c_last_ff;
   logic signed [gn3_pkg::VAL_W-1:0]  vc_ff;
   logic [gn3_pkg::T_W-1:0]           wc_ff [2];
   logic                              d_valid_ff, d_last_ff;
   logic signed [gn3_pkg::VAL_W-1:0]  vd_ff;
   logic [gn3_pkg::T_W-1:0]           wd_ff;
   logic                              e_valid_ff, e_last_ff;
   logic signed [gn3_pkg::VAL_W-1:0]  ve_ff;
   logic signed [gn3_pkg::ACC_W-1:0]  acc_ff, acc_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic signed [gn3_pkg::OUT_W-1:0]  rsp_data_ff;

   logic signed [gn3_pkg::SUM_W-1:0]  dot;
   logic signed [gn3_pkg::MUL_W-1:0]  mc, md, me;
   logic signed [gn3_pkg::ACC_W-1:0]  total;
   logic                              finish;

   // stall only when a finished sum meets an occupied result register
   assign adv    = !(e_valid_ff && e_last_ff && rsp_valid_ff && !rsp_ready);
   assign finish = e_valid_ff && e_last_ff && adv;

   assign dot   = p_ff[0] + p_ff[1] + p_ff[2];
   assign mc    = vb_ff * $signed({1'b0, wb_ff[0]});
   assign md    = vc_ff * $signed({1'b0, wc_ff[0]});
   assign me    = vd_ff * $signed({1'b0, wd_ff});
   assign total = acc_ff + ve_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= term_in.valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
         e_valid_ff <= d_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_last_ff <= term_in.last;
         p_ff[0]   <= term_in.gx * term_in.dx;
         p_ff[1]   <= term_in.gy * term_in.dy;
         p_ff[2]   <= term_in.gz * term_in.dz;
         wa_ff[0]  <= term_in.wx;
         wa_ff[1]  <= term_in.wy;
         wa_ff[2]  <= term_in.wz;
         b_last_ff <= a_last_ff;
         vb_ff     <= dot[gn3_pkg::SUM_W-1:F-2];
         wb_ff     <= wa_ff;
         c_last_ff <= b_last_ff;
         vc_ff     <= mc[F+gn3_pkg::VAL_W-1:F];
         wc_ff[0]  <= wb_ff[1];
         wc_ff[1]  <= wb_ff[2];
         d_last_ff <= c_last_ff;
         vd_ff     <= md[F+gn3_pkg::VAL_W-1:F];
         wd_ff     <= wc_ff[1];
         e_last_ff <= d_last_ff;
         ve_ff     <= me[F+gn3_pkg::VAL_W-1:F];
      end
   end

   always_comb begin
      acc_in = acc_ff;
      if (e_valid_ff && adv) begin
         acc_in = e_last_ff ? '0 : total;
      end
      rsp_valid_in = rsp_valid_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // saturate the corner sum into the result format
   always_ff @(posedge clock) begin
      if (finish) begin
         if (total > gn3_pkg::OUT_MAX) begin
            rsp_data_ff <= gn3_pkg::OUT_MAX[gn3_pkg::OUT_W-1:0];
         end else if (total < gn3_pkg::OUT_MIN) begin
            rsp_data_ff <= gn3_pkg::OUT_MIN[gn3_pkg::OUT_W-1:0];
         end else begin
            rsp_data_ff <= total[gn3_pkg::OUT_W-1:0];
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_noise_value = rsp_data_ff;

endmodule

[design/gradient_noise_3d.sv]
// ----------------------------------------------------------------------------
// gradient_noise_3d
// 3D gradient noise evaluator with loadable permutation and gradient tables.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_*): req_type selects a permutation load, a gradient
//   load or an evaluate. Loads return nothing; a load at an index beyond
//   the table is dropped. An evaluate returns one rsp_noise_value (Q4.16)
//   on the response channel.
//   Throughput: one lattice corner enters the pipeline per cycle unless the
//   pipeline stalls; an evaluate holds the request side until its last corner
//   has issued, while a load does not. Later items overlap earlier ones.
//   rsp_valid rises for an evaluate once its last corner has left the issue
//   register and passed four table/fade stages, five arithmetic stages and
//   the result register.
//   Tables are undefined after reset; write an entry before reading it.
//   Reset empties the pipeline and clears the response valid.
//   When the receiver stalls, the result is held and the pipeline keeps
//   running until the next result reaches the end, then it holds too.
// ----------------------------------------------------------------------------
module gradient_noise_3d (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_type,
   input  logic [gn3_pkg::TIDX_W-1:0]          req_table_index,
   input  logic [gn3_pkg::PERM_W-1:0]          req_perm_value,
   input  logic signed [gn3_pkg::GRAD_W-1:0]   req_grad_x,
   input  logic signed [gn3_pkg::GRAD_W-1:0]   req_grad_y,
   input  logic signed [gn3_pkg::GRAD_W-1:0]   req_grad_z,
   input  logic signed [gn3_pkg::COORD_W-1:0]  req_coord_x,
   input  logic signed [gn3_pkg::COORD_W-1:0]  req_coord_y,
   input  logic signed [gn3_pkg::COORD_W-1:0]  req_coord_z,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [gn3_pkg::OUT_W-1:0]    rsp_noise_value
);

   logic                   adv;
   gn3_pkg::corner_op_type op;
   gn3_pkg::term_type      term;

   gn3_issue u_issue (
      .clock           (clock),
      .reset           (reset),
      .adv             (adv),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_table_index (req_table_index),
      .req_perm_value  (req_perm_value),
      .req_grad_x      (req_grad_x),
      .req_grad_y      (req_grad_y),
      .req_grad_z      (req_grad_z),
      .req_coord_x     (req_coord_x),
      .req_coord_y     (req_coord_y),
      .req_coord_z     (req_coord_z),
      .op_out          (op)
   );

   gn3_lookup u_lookup (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .op_in    (op),
      .term_out (term)
   );

   gn3_weight u_weight (
      .clock           (clock),
      .reset           (reset),
      .term_in         (term),
      .adv             (adv),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_noise_value (rsp_noise_value)
   );

endmodule

[design/gn3_checker.sv]
// ----------------------------------------------------------------------------
// gn3_checker
// Port-level checks of the noise block, bound to the top level.
// ----------------------------------------------------------------------------
module gn3_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic [1:0]                       req_type,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic signed [gn3_pkg::OUT_W-1:0] rsp_noise_value
);

   // no result straight out of reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // an evaluate transfer blocks the request side while its corners issue
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_type == gn3_pkg::REQ_EVALUATE) |=> !req_ready)
      else $error("request taken during corner issue");

   // a stalled result stays offered
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("response dropped while stalled");

   // a stalled result keeps its value
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> $stable(rsp_noise_value))
      else $error("response changed while stalled");

endmodule

bind gradient_noise_3d gn3_checker u_gn3_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .req_type        (req_type),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_noise_value (rsp_noise_value)
);

[tb/gradient_noise_3d_test.sv]
// ----------------------------------------------------------------------------
// gradient_noise_3d_test
// Self-checking bench: fills both tables, runs directed and random loads and
// evaluates with random idling on both channels, and checks each noise value
// against an in-bench fixed-point predictor of the block or a typed-in value.
// ----------------------------------------------------------------------------
module gradient_noise_3d_test;
   import gn3_pkg::*;

   localparam logic [1:0] REQ_UNKNOWN = 2'd3;
   localparam int         IDX_MASK    = TABLE_SIZE - 1;
   localparam longint     FIX_ONE     = longint'(1) << FRAC_W;
   localparam longint     SAT_MAX     = (longint'(1) << (OUT_W - 1)) - 1;
   localparam longint     SAT_MIN     = -(longint'(1) << (OUT_W - 1));
   localparam int         CYCLE_LIMIT = 400000;
   localparam int         DRAIN_WAIT  = 40;
   localparam int         HOLD_CYCLES = 300;

   typedef struct {
      logic [1:0]                  kind;
      logic [TIDX_W-1:0]           index;
      logic [PERM_W-1:0]           perm;
      logic signed [GRAD_W-1:0]    gx, gy, gz;
      logic signed [COORD_W-1:0]   cx, cy, cz;
      bit                          typed;
      logic signed [OUT_W-1:0]     typed_val;
   } request_type;

   logic                        clock, reset;
   logic                        req_valid, req_ready;
   logic [1:0]                  req_type;
   logic [TIDX_W-1:0]           req_table_index;
   logic [PERM_W-1:0]           req_perm_value;
   logic signed [GRAD_W-1:0]    req_grad_x, req_grad_y, req_grad_z;
   logic signed [COORD_W-1:0]   req_coord_x, req_coord_y, req_coord_z;
   logic                        rsp_valid, rsp_ready;
   logic signed [OUT_W-1:0]     rsp_noise_value;

   // payload side info for rows whose result is typed in
   bit                          cur_typed;
   logic signed [OUT_W-1:0]     cur_typed_val;

   logic [PERM_W-1:0]           perm_copy [TABLE_SIZE];
   logic signed [GRAD_W-1:0]    grad_copy [TABLE_SIZE][3];
   logic signed [OUT_W-1:0]     noise_due [$];
   request_type                 stim [$];

   int  mismatches = 0;
   int  cycles = 0;
   bit  hold_rsp = 0;
   bit  calm_rsp = 0;

   gradient_noise_3d u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_type(req_type),
      .req_table_index(req_table_index), .req_perm_value(req_perm_value),
      .req_grad_x(req_grad_x), .req_grad_y(req_grad_y), .req_grad_z(req_grad_z),
      .req_coord_x(req_coord_x), .req_coord_y(req_coord_y),
      .req_coord_z(req_coord_z),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_noise_value(rsp_noise_value)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint fade_weight(longint t);
      longint t2;
      t2 = (t * t) >>> FRAC_W;
      return (t2 * (3 * FIX_ONE - 2 * t)) >>> FRAC_W;
   endfunction

   function automatic logic signed [OUT_W-1:0] noise_at(logic signed [COORD_W-1:0] cx,
                                                      logic signed [COORD_W-1:0] cy,
                                                      logic signed [COORD_W-1:0] cz);
      longint base [3];
      longint frac [3];
      longint q [3];
      longint dd [3];
      longint wt [3];
      longint acc, dot, v;
      int     hi, hx, hy, hz;
      logic signed [COORD_W-1:0] crd [3];
      crd[0] = cx; crd[1] = cy; crd[2] = cz;
      acc = 0;
      for (int a = 0; a < 3; a++) begin
         base[a] = longint'(crd[a]) >>> FRAC_W;
         frac[a] = longint'(crd[a]) & (FIX_ONE - 1);
      end
      for (int c = 0; c < 8; c++) begin
         for (int a = 0; a < 3; a++) begin
            hi = (c >> a) & 1;
            q[a]  = base[a] + hi;
            dd[a] = hi ? frac[a] - FIX_ONE : frac[a];
            wt[a] = fade_weight(hi ? frac[a] : FIX_ONE - frac[a]);
         end
         hx = int'(perm_copy[q[0] & IDX_MASK]);
         hy = int'(perm_copy[(q[1] + hx) & IDX_MASK]);
         hz = int'(perm_copy[(q[2] + hy) & IDX_MASK]);
         dot = 0;
         for (int a = 0; a < 3; a++)
            dot += longint'(grad_copy[hz][a]) * dd[a];
         v = dot >>> (FRAC_W - 2);
         for (int a = 0; a < 3; a++)
            v = (v * wt[a]) >>> FRAC_W;
         acc += v;
      end
      if (acc > SAT_MAX) acc = SAT_MAX;
      if (acc < SAT_MIN) acc = SAT_MIN;
      return acc[OUT_W-1:0];
   endfunction

   function automatic request_type blank_req(logic [1:0] kind);
      request_type r;
      r.kind = kind;
      r.index = '0; r.perm = '0;
      r.gx = '0; r.gy = '0; r.gz = '0;
      r.cx = '0; r.cy = '0; r.cz = '0;
      r.typed = 0; r.typed_val = '0;
      return r;
   endfunction

   function automatic request_type perm_load(int idx, int val);
      request_type r;
      r = blank_req(REQ_LOAD_PERM);
      r.index = TIDX_W'(idx); r.perm = PERM_W'(val);
      return r;
   endfunction

   function automatic request_type grad_load(int idx, int x, int y, int z);
      request_type r;
      r = blank_req(REQ_LOAD_GRAD);
      r.index = TIDX_W'(idx);
      r.gx = GRAD_W'(x); r.gy = GRAD_W'(y); r.gz = GRAD_W'(z);
      return r;
   endfunction

   function automatic request_type eval_at(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      request_type r;
      r = blank_req(REQ_EVALUATE);
      r.cx = x; r.cy = y; r.cz = z;
      return r;
   endfunction

   function automatic int rand_grad();
      if ($urandom_range(0, 9) == 0)
         return $signed(16'($urandom));
      return $urandom_range(0, 32768) - 16384;
   endfunction

   function automatic logic [31:0] rand_coord();
      logic [31:0] edge_pt;
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return $urandom_range(0, 32'h7_FFFF) - 32'h4_0000;
         2: begin
            // on a lattice plane, or just below one
            edge_pt = {16'($urandom_range(0, 65535)), 16'h0000};
            return $urandom_range(0, 1) ? (edge_pt ^ 32'hFFFF) : edge_pt;
         end
         default: return $urandom_range(0, 32'h3FF_FFFF);
      endcase
   endfunction

   // record each transfer and check each result against the oldest noise due
   always @(posedge clock) begin
      if (!reset) begin
         cycles <= cycles + 1;
         if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
         if (req_valid && req_ready) begin
            case (req_type)
               REQ_LOAD_PERM: perm_copy[req_table_index] = req_perm_value;
               REQ_LOAD_GRAD: begin
                  grad_copy[req_table_index][0] = req_grad_x;
                  grad_copy[req_table_index][1] = req_grad_y;
                  grad_copy[req_table_index][2] = req_grad_z;
               end
               REQ_EVALUATE:
                  noise_due.push_back(cur_typed ? cur_typed_val
                                      : noise_at(req_coord_x, req_coord_y, req_coord_z));
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (noise_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected noise value %0d", rsp_noise_value);
            end else begin
               if (rsp_noise_value !== noise_due[0]) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("noise_value: expected %0d, got %0d",
                              noise_due[0], rsp_noise_value);
               end
               void'(noise_due.pop_front());
            end
         end
      end
   end

   // receiver: random stalls, one long hold-off, and a calm stretch
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            hold_rsp = 0;
         end else if (calm_rsp) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= 9);
         end
      end
   end

   initial begin
      request_type r;
      int n;
      req_valid = 1'b0; req_type = REQ_UNKNOWN; req_table_index = '0;
      req_perm_value = '0; req_grad_x = '0; req_grad_y = '0; req_grad_z = '0;
      req_coord_x = '0; req_coord_y = '0; req_coord_z = '0;
      cur_typed = 0; cur_typed_val = '0;
      reset = 1'b1;

      // write every entry before any evaluate can read one
      for (int i = 0; i < TABLE_SIZE; i++) begin
         stim.push_back(perm_load(i, $urandom_range(0, 255)));
         stim.push_back(grad_load(i, rand_grad(), rand_grad(), rand_grad()));
      end

      r = eval_at(32'h0, 32'h0, 32'h0);
      r.typed = 1; r.typed_val = '0;
      stim.push_back(r);
      r = eval_at(32'h0001_0000, 32'hFFFE_0000, 32'h7FFF_0000);
      r.typed = 1; r.typed_val = '0;
      stim.push_back(r);
      stim.push_back(perm_load(0, 255));
      stim.push_back(perm_load(255, 0));
      stim.push_back(grad_load(0, 32767, -32768, 16384));
      stim.push_back(grad_load(255, -16384, 16384, -32768));
      stim.push_back(grad_load(1, 16384, 16384, 16384));
      stim.push_back(eval_at(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
      stim.push_back(eval_at(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
      stim.push_back(eval_at(32'h0000_8000, 32'h0000_8000, 32'h0000_8000));
      stim.push_back(eval_at(32'h0000_FFFF, 32'hFFFF_FFFF, 32'h0000_0001));
      stim.push_back(eval_at(32'hFFFF_0001, 32'h00FF_C000, 32'h8000_FFFF));
      r = blank_req(REQ_UNKNOWN);
      r.index = 8'hFF; r.perm = 8'hFF; r.gx = -1; r.gy = -1; r.gz = -1;
      r.cx = -1; r.cy = -1; r.cz = -1;
      stim.push_back(r);
      stim.push_back(eval_at(32'h0000_4000, 32'h00FF_4000, 32'hFF00_C000));

      for (int i = 0; i < 1400; i++) begin
         n = $urandom_range(0, 99);
         if (n < 75)
            stim.push_back(eval_at(rand_coord(), rand_coord(), rand_coord()));
         else if (n < 85)
            stim.push_back(perm_load($urandom_range(0, 255), $urandom_range(0, 255)));
         else if (n < 95)
            stim.push_back(grad_load($urandom_range(0, 255), rand_grad(), rand_grad(),
                                     rand_grad()));
         else begin
            r = eval_at($urandom, $urandom, $urandom);
            r.kind = REQ_UNKNOWN;
            stim.push_back(r);
         end
      end

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < stim.size(); i++) begin
         if (i == 900) hold_rsp = 1;
         if (i == 1300) begin
            // drop valid, then wait for every result still due
            @(negedge clock);
            req_valid <= 1'b0;
            while (noise_due.size() != 0) @(negedge clock);
         end
         calm_rsp = (i >= 1400 && i < 1650);
         @(negedge clock);
         while (!(i >= 1400 && i < 1650) && $urandom_range(0, 99) < 9) begin
            req_valid <= 1'b0;
            @(negedge clock);
         end
         r = stim[i];
         req_valid <= 1'b1;
         req_type <= r.kind;
         req_table_index <= r.index;
         req_perm_value <= r.perm;
         req_grad_x <= r.gx; req_grad_y <= r.gy; req_grad_z <= r.gz;
         req_coord_x <= r.cx; req_coord_y <= r.cy; req_coord_z <= r.cz;
         cur_typed <= r.typed;
         cur_typed_val <= r.typed_val;
         do @(posedge clock); while (!(req_valid && req_ready));
      end
      @(negedge clock);
      req_valid <= 1'b0;

      while (noise_due.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatches == 0 && noise_due.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
